// File: design/hcbd_pkg.sv
// ----------------------------------------------------------------------------
// hcbd_pkg: shared types and constants for the chunked body decoder
// Parse modes, error codes, character codes and the transaction structs.
// ----------------------------------------------------------------------------
package hcbd_pkg;

   // Parse modes of the chunk parser
   typedef enum logic [3:0] {
      MODE_SIZE     = 4'd0,
      MODE_EXT      = 4'd1,
      MODE_SIZE_LF  = 4'd2,
      MODE_DATA     = 4'd3,
      MODE_DATA_CR  = 4'd4,
      MODE_DATA_LF  = 4'd5,
      MODE_TR_START = 4'd6,
      MODE_TR_LINE  = 4'd7,
      MODE_TR_LF    = 4'd8,
      MODE_FINAL_LF = 4'd9,
      MODE_DONE     = 4'd10
   } mode_type;

   // Error codes
   localparam logic [2:0] ERR_NONE        = 3'd0;
   localparam logic [2:0] ERR_BAD_SIZE    = 3'd1;
   localparam logic [2:0] ERR_OVERFLOW    = 3'd2;
   localparam logic [2:0] ERR_DATA_CRLF   = 3'd3;
   localparam logic [2:0] ERR_NON_ASCII   = 3'd4;
   localparam logic [2:0] ERR_NO_COLON    = 3'd5;

   // Character codes
   localparam logic [7:0] CHAR_CR    = 8'h0D;
   localparam logic [7:0] CHAR_LF    = 8'h0A;
   localparam logic [7:0] CHAR_SEMI  = 8'h3B;
   localparam logic [7:0] CHAR_COLON = 8'h3A;

   // One input transaction
   typedef struct packed {
      logic [7:0] data_byte;
      logic       restart;
   } req_type;

   // One result transaction
   typedef struct packed {
      logic [7:0] body_byte;
      logic       body_valid;
      logic       message_done;
      logic [2:0] error_code;
   } rsp_type;

   // Decode one ASCII hex digit: {is_hex, value}
   function automatic logic [4:0] hex_decode(input logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (c >= 8'h30 && c <= 8'h39) begin
         r = {1'b1, 4'(c - 8'h30)};
      end else if (c >= 8'h61 && c <= 8'h66) begin
         r = {1'b1, 4'(c - 8'h57)};
      end else if (c >= 8'h41 && c <= 8'h46) begin
         r = {1'b1, 4'(c - 8'h37)};
      end
      return r;
   endfunction

endpackage

// File: design/hcbd_req_if.sv
// ----------------------------------------------------------------------------
// hcbd_req_if: input channel of the chunked body decoder
// Valid/ready channel carrying one body byte and the restart mark.
// ----------------------------------------------------------------------------
interface hcbd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;
   logic       restart;

   modport source (output valid, output data_byte, output restart, input ready);
   modport sink   (input valid, input data_byte, input restart, output ready);
endinterface

// File: design/hcbd_rsp_if.sv
// ----------------------------------------------------------------------------
// hcbd_rsp_if: result channel of the chunked body decoder
// Valid/ready channel carrying one decoded result per input byte.
// ----------------------------------------------------------------------------
interface hcbd_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] body_byte;
   logic       body_valid;
   logic       message_done;
   logic [2:0] error_code;

   modport source (output valid, output body_byte, output body_valid,
                   output message_done, output error_code, input ready);
   modport sink   (input valid, input body_byte, input body_valid,
                   input message_done, input error_code, output ready);
endinterface

// File: design/hcbd_step.sv
// ----------------------------------------------------------------------------
// hcbd_step: chunk parser state and per-byte step logic
// Holds the parse state and computes the result of one byte combinationally.
// ----------------------------------------------------------------------------
module hcbd_step
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    fire,
   input  req_type item,
   output rsp_type result
);

   mode_type             mode_ff, mode_in;
   logic [SIZE_BITS-1:0] count_ff, count_in;
   logic                 digit_ff, digit_in;
   logic                 colon_ff, colon_in;
   logic [2:0]           err_ff, err_in;

   // Effective current state: restart clears everything before the byte
   mode_type             cur_mode;
   logic [SIZE_BITS-1:0] cur_count;
   logic                 cur_digit;
   logic                 cur_colon;
   logic [2:0]           cur_err;

   logic [7:0] c;
   logic [4:0] hex;
   logic       is_cr, is_lf, is_semi;
   logic       size_full;
   mode_type   tr_mode;
   logic       tr_bad;
   logic       tr_colon;

   logic       valid_raw, done_raw;
   logic [7:0] byte_raw;

   assign c         = item.data_byte;
   assign hex       = hex_decode(c);
   assign is_cr     = (c == CHAR_CR);
   assign is_lf     = (c == CHAR_LF);
   assign is_semi   = (c == CHAR_SEMI);

   assign cur_mode  = item.restart ? MODE_SIZE : mode_ff;
   assign cur_count = item.restart ? '0 : count_ff;
   assign cur_digit = item.restart ? 1'b0 : digit_ff;
   assign cur_colon = item.restart ? 1'b0 : colon_ff;
   assign cur_err   = item.restart ? ERR_NONE : err_ff;

   // Another digit would overflow when the top nibble is already in use
   assign size_full = (cur_count[SIZE_BITS-1 -: 4] != 4'd0);

   // Plain byte inside a trailer line
   assign tr_bad   = c[7];
   assign tr_mode  = is_cr ? MODE_TR_LF : MODE_TR_LINE;
   assign tr_colon = !tr_bad && (c == CHAR_COLON);

   // Next parse mode and error
   always_comb begin
      mode_in = cur_mode;
      err_in  = cur_err;
      if (cur_err == ERR_NONE) begin
         unique case (cur_mode)
            MODE_SIZE: begin
               if (hex[4]) begin
                  if (size_full) err_in = ERR_OVERFLOW;
               end else if (is_semi || is_cr) begin
                  if (!cur_digit) err_in = ERR_BAD_SIZE;
                  else mode_in = is_semi ? MODE_EXT : MODE_SIZE_LF;
               end else begin
                  err_in = ERR_BAD_SIZE;
               end
            end
            MODE_EXT: begin
               if (is_cr) mode_in = MODE_SIZE_LF;
            end
            MODE_SIZE_LF: begin
               if (!is_lf) err_in = ERR_BAD_SIZE;
               else if (cur_count == '0) mode_in = MODE_TR_START;
               else mode_in = MODE_DATA;
            end
            MODE_DATA: begin
               if (cur_count == SIZE_BITS'(1)) mode_in = MODE_DATA_CR;
            end
            MODE_DATA_CR: begin
               if (is_cr) mode_in = MODE_DATA_LF;
               else err_in = ERR_DATA_CRLF;
            end
            MODE_DATA_LF: begin
               if (is_lf) mode_in = MODE_SIZE;
               else err_in = ERR_DATA_CRLF;
            end
            MODE_TR_START: begin
               if (is_cr) mode_in = MODE_FINAL_LF;
               else if (tr_bad) err_in = ERR_NON_ASCII;
               else mode_in = tr_mode;
            end
            MODE_TR_LINE: begin
               if (tr_bad) err_in = ERR_NON_ASCII;
               else mode_in = tr_mode;
            end
            MODE_TR_LF: begin
               if (is_lf) begin
                  if (!cur_colon) err_in = ERR_NO_COLON;
                  else mode_in = MODE_TR_START;
               end else if (tr_bad) begin
                  err_in = ERR_NON_ASCII;
               end else begin
                  mode_in = tr_mode;
               end
            end
            MODE_FINAL_LF: begin
               if (is_lf) mode_in = MODE_DONE;
               else if (tr_bad) err_in = ERR_NON_ASCII;
               else mode_in = tr_mode;
            end
            MODE_DONE: begin
               mode_in = MODE_DONE;
            end
            default: begin
               mode_in = MODE_DONE;
            end
         endcase
      end
   end

   // Counter, flags and raw outputs
   always_comb begin
      count_in  = cur_count;
      digit_in  = cur_digit;
      colon_in  = cur_colon;
      valid_raw = 1'b0;
      done_raw  = 1'b0;
      byte_raw  = 8'd0;
      if (cur_err == ERR_NONE) begin
         unique case (cur_mode)
            MODE_SIZE: begin
               if (hex[4] && !size_full) begin
                  count_in = {cur_count[SIZE_BITS-5:0], hex[3:0]};
                  digit_in = 1'b1;
               end
            end
            MODE_SIZE_LF: begin
               if (is_lf && cur_count == '0) colon_in = 1'b0;
            end
            MODE_DATA: begin
               valid_raw = 1'b1;
               byte_raw  = c;
               count_in  = cur_count - SIZE_BITS'(1);
            end
            MODE_DATA_LF: begin
               if (is_lf) begin
                  count_in = '0;
                  digit_in = 1'b0;
               end
            end
            MODE_TR_START, MODE_TR_LINE: begin
               if (tr_colon) colon_in = 1'b1;
            end
            MODE_TR_LF: begin
               if (is_lf) colon_in = 1'b0;
               else if (tr_colon) colon_in = 1'b1;
            end
            MODE_FINAL_LF: begin
               if (is_lf) done_raw = 1'b1;
               else if (tr_colon) colon_in = 1'b1;
            end
            default: begin
               count_in = cur_count;
            end
         endcase
      end
   end

   // Drop payload and done flags while an error stands
   always_comb begin
      result.error_code   = err_in;
      result.body_valid   = (err_in == ERR_NONE) ? valid_raw : 1'b0;
      result.message_done = (err_in == ERR_NONE) ? done_raw : 1'b0;
      result.body_byte    = (err_in == ERR_NONE) ? byte_raw : 8'd0;
   end

   // Advance the parse state once per processed transaction
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= MODE_SIZE;
         count_ff <= '0;
         digit_ff <= 1'b0;
         colon_ff <= 1'b0;
         err_ff   <= ERR_NONE;
      end else if (fire) begin
         mode_ff  <= mode_in;
         count_ff <= count_in;
         digit_ff <= digit_in;
         colon_ff <= colon_in;
         err_ff   <= err_in;
      end
   end

endmodule

// File: design/http_chunked_body_decoder.sv
// ----------------------------------------------------------------------------
// http_chunked_body_decoder: HTTP/1.1 chunked transfer body decoder
// Decodes a chunked body one byte per transaction with sticky error report.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one body byte per transaction plus a restart mark that
//   clears the parser before that byte is handled (first byte of a body).
//   rsp_ch returns exactly one result per input byte: the payload byte with
//   body_valid, message_done on the LF ending the trailer section, and the
//   sticky error code (0 when none).
//   Two register stages: input register, then result register; a byte
//   accepted on req_ch is parsed between them and then shows on rsp_ch.
//   Throughput: one byte per cycle while rsp_ch takes results; the parser
//   state and the chunk down counter update as a byte moves into the result register.
//   When rsp_ch stalls, the result register holds; the input register still
//   takes one more byte, after which req_ch.ready drops until the result
//   moves on.
//   Reset (synchronous, active high) empties both stages and returns the
//   parser to expecting a chunk size digit with no error.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder
   import hcbd_pkg::*;
#(
   parameter int SIZE_BITS = 32
) (
   input logic          clock,
   input logic          reset,
   hcbd_req_if.sink     req_ch,
   hcbd_rsp_if.source   rsp_ch
);

   logic    in_valid_ff, in_valid_in;
   req_type in_item_ff;
   logic    out_valid_ff, out_valid_in;
   rsp_type out_item_ff;
   rsp_type step_result;
   logic    out_free;
   logic    step_fire;
   logic    req_fire;

   // Handshake between the two stages
   assign out_free     = !out_valid_ff || rsp_ch.ready;
   assign step_fire    = in_valid_ff && out_free;
   assign req_ch.ready = !in_valid_ff || out_free;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign in_valid_in  = req_fire || (in_valid_ff && !out_free);
   assign out_valid_in = step_fire || (out_valid_ff && !rsp_ch.ready);

   // Parse one byte
   hcbd_step #(
      .SIZE_BITS (SIZE_BITS)
   ) u_step (
      .clock  (clock),
      .reset  (reset),
      .fire   (step_fire),
      .item   (in_item_ff),
      .result (step_result)
   );

   // Valid bits of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // Capture input and result payloads
   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_item_ff.data_byte <= req_ch.data_byte;
         in_item_ff.restart   <= req_ch.restart;
      end
      if (step_fire) begin
         out_item_ff <= step_result;
      end
   end

   assign rsp_ch.valid        = out_valid_ff;
   assign rsp_ch.body_byte    = out_item_ff.body_byte;
   assign rsp_ch.body_valid   = out_item_ff.body_valid;
   assign rsp_ch.message_done = out_item_ff.message_done;
   assign rsp_ch.error_code   = out_item_ff.error_code;

endmodule

// File: dv/http_chunked_body_decoder_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// http_chunked_body_decoder_tb: self-checking bench for the chunked decoder
// Feeds chunked bodies one byte per transaction and predicts each result
// with a behavioral parser. Directed tests cover size forms, every error and
// trailer corner. Random tests then send well-formed messages with random
// content, with some corrupted or cut short. Bursty input and a stalling
// receiver put gaps on every phase of the parse.
// ----------------------------------------------------------------------------
module http_chunked_body_decoder_tb
   import hcbd_pkg::*;
();

   localparam int          SIZE_BITS    = 32;
   localparam logic [63:0] SIZE_MAX     = {64{1'b1}} >> (64 - SIZE_BITS);
   localparam int          CYCLE_LIMIT  = 400000;
   localparam int          HOLD_CYCLES  = 64;
   localparam int          RANDOM_ITEMS = 900;
   localparam int          REPORT_LIMIT = 10;
   localparam int          DRAIN_CYCLES = 10;
   // In directed text, these marks stand for CR and LF
   localparam logic [7:0]  MARK_CR      = "^";
   localparam logic [7:0]  MARK_LF      = "~";

   typedef enum {RX_OPEN, RX_COIN, RX_SPARSE} rx_style_type;

   logic clock = 1'b0;
   logic reset;

   hcbd_req_if req_ch ();
   hcbd_rsp_if rsp_ch ();

   http_chunked_body_decoder #(.SIZE_BITS(SIZE_BITS)) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Parser state mirrored by the predictor
   mode_type    dec_mode;
   logic [63:0] dec_remaining;
   logic        dec_digit_seen;
   logic        dec_colon_seen;
   logic [2:0]  dec_error;

   rsp_type     expected_results[$];
   logic [7:0]  msg_bytes[$];

   int unsigned cycle_count     = 0;
   int unsigned bytes_sent      = 0;
   int unsigned results_checked = 0;
   int unsigned payload_seen    = 0;
   int unsigned messages_done   = 0;
   int unsigned failures        = 0;
   int unsigned error_hits[8];
   int          burst_left      = 0;
   bit          tx_steady       = 1'b0;
   bit          hold_request    = 1'b0;

   // ------------------------------------------------------------------
   // Predictor
   // ------------------------------------------------------------------
   function automatic int hex_digit_value(input logic [7:0] c);
      if (c >= "0" && c <= "9") return int'(c) - int'("0");
      if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
      if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
      return -1;
   endfunction

   function automatic void decoder_clear();
      dec_mode       = MODE_SIZE;
      dec_remaining  = '0;
      dec_digit_seen = 1'b0;
      dec_colon_seen = 1'b0;
      dec_error      = ERR_NONE;
   endfunction

   // Handle a trailer line byte other than LF, also after a lone CR; a CR waits for LF
   function automatic void trailer_char(input logic [7:0] c);
      if (c[7]) begin
         dec_error = ERR_NON_ASCII;
      end else if (c == CHAR_CR) begin
         dec_mode = MODE_TR_LF;
      end else begin
         if (c == CHAR_COLON) dec_colon_seen = 1'b1;
         dec_mode = MODE_TR_LINE;
      end
   endfunction

   function automatic rsp_type decode_byte(input logic [7:0] c, input logic rst);
      rsp_type r;
      int      digit;
      r = '0;
      if (rst) decoder_clear();
      if (dec_error == ERR_NONE) begin
         case (dec_mode)
            MODE_SIZE: begin
               digit = hex_digit_value(c);
               if (digit >= 0) begin
                  if (dec_remaining > (SIZE_MAX >> 4)) begin
                     dec_error = ERR_OVERFLOW;
                  end else begin
                     dec_remaining  = {dec_remaining[59:0], 4'(digit)};
                     dec_digit_seen = 1'b1;
                  end
               end else if (c == CHAR_SEMI || c == CHAR_CR) begin
                  if (!dec_digit_seen) dec_error = ERR_BAD_SIZE;
                  else dec_mode = (c == CHAR_SEMI) ? MODE_EXT : MODE_SIZE_LF;
               end else begin
                  dec_error = ERR_BAD_SIZE;
               end
            end
            MODE_EXT: begin
               if (c == CHAR_CR) dec_mode = MODE_SIZE_LF;
            end
            MODE_SIZE_LF: begin
               if (c != CHAR_LF) begin
                  dec_error = ERR_BAD_SIZE;
               end else if (dec_remaining == 0) begin
                  dec_mode       = MODE_TR_START;
                  dec_colon_seen = 1'b0;
               end else begin
                  dec_mode = MODE_DATA;
               end
            end
            MODE_DATA: begin
               r.body_valid  = 1'b1;
               r.body_byte   = c;
               dec_remaining = dec_remaining - 1;
               if (dec_remaining == 0) dec_mode = MODE_DATA_CR;
            end
            MODE_DATA_CR: begin
               if (c == CHAR_CR) dec_mode = MODE_DATA_LF;
               else dec_error = ERR_DATA_CRLF;
            end
            MODE_DATA_LF: begin
               if (c == CHAR_LF) begin
                  dec_mode       = MODE_SIZE;
                  dec_remaining  = '0;
                  dec_digit_seen = 1'b0;
               end else begin
                  dec_error = ERR_DATA_CRLF;
               end
            end
            MODE_TR_START: begin
               if (c == CHAR_CR) dec_mode = MODE_FINAL_LF;
               else trailer_char(c);
            end
            MODE_TR_LINE: begin
               trailer_char(c);
            end
            MODE_TR_LF: begin
               if (c == CHAR_LF) begin
                  if (!dec_colon_seen) begin
                     dec_error = ERR_NO_COLON;
                  end else begin
                     dec_mode       = MODE_TR_START;
                     dec_colon_seen = 1'b0;
                  end
               end else begin
                  trailer_char(c);
               end
            end
            MODE_FINAL_LF: begin
               if (c == CHAR_LF) begin
                  r.message_done = 1'b1;
                  dec_mode       = MODE_DONE;
               end else begin
                  trailer_char(c);
               end
            end
            default: begin
               dec_mode = MODE_DONE;
            end
         endcase
      end
      // Mask everything but the code while an error is held
      if (dec_error != ERR_NONE) r = '0;
      r.error_code = dec_error;
      return r;
   endfunction

   // ------------------------------------------------------------------
   // Sender and message assembly
   // ------------------------------------------------------------------
   // Offer one byte, in bursts with random gaps unless tx_steady is set; predict on acceptance
   task automatic send_byte(input logic [7:0] b, input logic rst);
      int gap;
      if (!tx_steady) begin
         if (burst_left == 0) begin
            gap = $urandom_range(1, 5);
            req_ch.valid <= 1'b0;
            repeat (gap) @(negedge clock);
            burst_left = $urandom_range(1, 20);
         end
         burst_left--;
      end
      req_ch.valid     <= 1'b1;
      req_ch.data_byte <= b;
      req_ch.restart   <= rst;
      do @(posedge clock); while (!req_ch.ready);
      expected_results.push_back(decode_byte(b, rst));
      bytes_sent++;
      @(negedge clock);
   endtask

   function automatic void add_byte(input logic [7:0] b);
      msg_bytes.push_back(b);
   endfunction

   function automatic void add_text(input string s);
      foreach (s[i]) begin
         if (s[i] == MARK_CR) add_byte(CHAR_CR);
         else if (s[i] == MARK_LF) add_byte(CHAR_LF);
         else add_byte(s[i]);
      end
   endfunction

   task automatic send_message(input logic with_restart);
      foreach (msg_bytes[i]) send_byte(msg_bytes[i], with_restart && i == 0);
   endtask

   task automatic send_text(input string s, input logic with_restart);
      msg_bytes.delete();
      add_text(s);
      send_message(with_restart);
   endtask

   // Size line with random case, optional leading zeros and extension
   function automatic void add_chunk_line(input int chunk_len);
      string      digits;
      logic [7:0] b;
      digits = $sformatf("%0h", chunk_len);
      if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 3)) add_byte("0");
      foreach (digits[i]) begin
         if (digits[i] >= "a" && $urandom_range(0, 1) == 1) add_byte(digits[i] - 8'h20);
         else add_byte(digits[i]);
      end
      if ($urandom_range(0, 3) == 0) begin
         add_byte(CHAR_SEMI);
         repeat ($urandom_range(0, 6)) begin
            b = 8'($urandom_range(0, 255));
            add_byte((b == CHAR_CR) ? CHAR_SEMI : b);
         end
      end
      add_text("^~");
   endfunction

   // Well-formed chunked body with random content, sometimes broken
   function automatic void build_random_message();
      int         chunks;
      int         chunk_len;
      int         cut;
      logic [7:0] b;
      msg_bytes.delete();
      chunks = $urandom_range(0, 4);
      repeat (chunks) begin
         chunk_len = ($urandom_range(0, 9) == 0) ? $urandom_range(25, 300)
                                                 : $urandom_range(1, 24);
         add_chunk_line(chunk_len);
         repeat (chunk_len) add_byte(8'($urandom_range(0, 255)));
         add_text("^~");
      end
      add_chunk_line(0);
      repeat ($urandom_range(0, 2)) begin
         repeat ($urandom_range(1, 6)) begin
            b = 8'($urandom_range(33, 126));
            add_byte((b == CHAR_COLON) ? "h" : b);
         end
         // keep a lone CR inside the line now and then
         if ($urandom_range(0, 4) == 0) begin
            add_byte(CHAR_CR);
            add_byte("x");
         end
         if ($urandom_range(0, 7) != 0) add_byte(CHAR_COLON);
         repeat ($urandom_range(0, 8)) add_byte(8'($urandom_range(32, 126)));
         add_text("^~");
      end
      add_text("^~");
      // break a few messages: overwrite one byte or cut the tail
      case ($urandom_range(0, 9))
         0, 1: begin
            msg_bytes[$urandom_range(0, msg_bytes.size() - 1)] = 8'($urandom_range(0, 255));
         end
         2: begin
            cut = $urandom_range(1, msg_bytes.size() - 1);
            while (msg_bytes.size() > cut) void'(msg_bytes.pop_back());
         end
         default: begin
         end
      endcase
   endfunction

   // ------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------
   task automatic test_basic_message();
      // first body right after reset, no restart mark
      send_text("4^~Wiki^~5;name=val^~pedia^~0^~^~", 1'b0);
      // bytes after message end are ignored
      send_text("zz", 1'b0);
      // payload extremes, CR as payload
      msg_bytes.delete();
      add_text("3^~");
      add_byte(8'h00);
      add_byte(8'hFF);
      add_byte(CHAR_CR);
      add_text("^~0^~^~");
      send_message(1'b1);
   endtask

   task automatic test_size_forms();
      send_text("0000A;ext^~0123456789^~B^~abcdefghijk^~000^~^~", 1'b1);
      send_text("000000000001^~Q^~0^~^~", 1'b1);
      // largest size the counter holds, then abandon it
      send_text("FFFFFFFF^~xyz", 1'b1);
      send_text("ffffffff;^~q", 1'b1);
   endtask

   task automatic test_size_errors();
      send_text(";x1^~", 1'b1);
      send_text("^~", 1'b1);
      send_text("1g", 1'b1);
      send_text("5^X", 1'b1);
      send_text("1;e^X", 1'b1);
      send_text("100000000^~", 1'b1);
      send_text("FFFFFFFF0", 1'b1);
   endtask

   task automatic test_data_crlf_errors();
      send_text("2^~abX", 1'b1);
      send_text("2^~ab^X", 1'b1);
   endtask

   task automatic test_trailers();
      send_text("0^~Name: v^~A:b^~^~", 1'b1);
      send_text("0^~A^B:c^~^~", 1'b1);
      send_text("0^~^X:y^~^~", 1'b1);
      send_text("0^~A:^^~^~", 1'b1);
      send_text("0^~abc^~", 1'b1);
      send_text("0^~^X^~", 1'b1);
      msg_bytes.delete();
      add_text("0^~A:");
      add_byte(8'h7F);
      add_byte(8'h80);
      send_message(1'b1);
      msg_bytes.delete();
      add_text("0^~");
      add_byte(8'hFF);
      send_message(1'b1);
   endtask

   task automatic test_restart_midstream();
      send_text("5^~ab", 1'b1);
      send_text("3^~xyz^~0^~^~", 1'b1);
      send_text("1g", 1'b1);
      send_text("1^~z^~0^~^~", 1'b1);
   endtask

   // Hold the result side off while input keeps coming
   task automatic test_output_hold_off();
      tx_steady    = 1'b1;
      hold_request = 1'b1;
      repeat (2) begin
         build_random_message();
         send_message(1'b1);
      end
      tx_steady = 1'b0;
   endtask

   task automatic test_random_messages();
      int sent;
      sent = 0;
      while (sent < RANDOM_ITEMS) begin
         build_random_message();
         sent += msg_bytes.size();
         // trailing junk after the body is ignored by the block
         if ($urandom_range(0, 7) == 0) repeat ($urandom_range(1, 4)) add_byte("j");
         tx_steady = ($urandom_range(0, 3) == 0);
         send_message(1'b1);
      end
      tx_steady = 1'b0;
   endtask

   // ------------------------------------------------------------------
   // Receiver: stall pattern of its own, plus one long hold-off
   // ------------------------------------------------------------------
   initial begin : result_receiver
      int           hold_left;
      int           style_left;
      rx_style_type style;
      hold_left     = 0;
      style_left    = 0;
      style         = RX_OPEN;
      rsp_ch.ready  = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            if (style_left == 0) begin
               style      = rx_style_type'($urandom_range(0, 2));
               style_left = $urandom_range(16, 128);
            end
            style_left--;
            case (style)
               RX_OPEN: rsp_ch.ready <= 1'b1;
               RX_COIN: rsp_ch.ready <= 1'($urandom_range(0, 1));
               default: rsp_ch.ready <= ($urandom_range(0, 7) != 0);
            endcase
         end
      end
   end

   // ------------------------------------------------------------------
   // Result checker
   // ------------------------------------------------------------------
   task automatic log_failure(input string what, input rsp_type want, input rsp_type got);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%s at cycle %0d: expected byte %02h valid %0b done %0b err %0d, got byte %02h valid %0b done %0b err %0d",
                  what, cycle_count, want.body_byte, want.body_valid, want.message_done,
                  want.error_code, got.body_byte, got.body_valid, got.message_done,
                  got.error_code);
      end
   endtask

   always @(posedge clock) begin : check_results
      rsp_type got;
      rsp_type want;
      got = {rsp_ch.body_byte, rsp_ch.body_valid, rsp_ch.message_done, rsp_ch.error_code};
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         results_checked++;
         if (expected_results.size() == 0) begin
            log_failure("Unexpected result", '0, got);
         end else begin
            want = expected_results.pop_front();
            if (got.body_byte !== want.body_byte || got.body_valid !== want.body_valid ||
                got.message_done !== want.message_done ||
                got.error_code !== want.error_code) begin
               log_failure("Result mismatch", want, got);
            end
            payload_seen  += want.body_valid;
            messages_done += want.message_done;
            error_hits[want.error_code]++;
         end
      end
   end

   // Watchdog: end the run as failed once cycle_count reaches CYCLE_LIMIT
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("http_chunked_body_decoder test failed");
      $finish;
   end

   // ------------------------------------------------------------------
   // Main sequence
   // ------------------------------------------------------------------
   initial begin
      reset            = 1'b1;
      req_ch.valid     = 1'b0;
      req_ch.data_byte = '0;
      req_ch.restart   = 1'b0;
      foreach (error_hits[i]) error_hits[i] = 0;
      decoder_clear();
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_basic_message();
      test_size_forms();
      test_size_errors();
      test_data_crlf_errors();
      test_trailers();
      test_restart_midstream();
      test_output_hold_off();
      test_random_messages();

      // drop valid and drain the outstanding results
      req_ch.valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d bytes, checked %0d results: %0d payload bytes, %0d message ends",
               bytes_sent, results_checked, payload_seen, messages_done);
      $display("Results under error: bad size %0d, overflow %0d, data CRLF %0d, non-ASCII %0d, no colon %0d",
               error_hits[ERR_BAD_SIZE], error_hits[ERR_OVERFLOW], error_hits[ERR_DATA_CRLF],
               error_hits[ERR_NON_ASCII], error_hits[ERR_NO_COLON]);
      if (failures == 0) begin
         $display("http_chunked_body_decoder test passed");
      end else begin
         $display("http_chunked_body_decoder test failed");
      end
      $finish;
   end

endmodule

// File: sim.f
design/hcbd_pkg.sv
design/hcbd_req_if.sv
design/hcbd_rsp_if.sv
design/hcbd_step.sv
design/http_chunked_body_decoder.sv
dv/http_chunked_body_decoder_tb.sv
